// ----- design/replication_zoom_address_generator_core_assert.svh -----
// Assertion macros shared by the zoom address generator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef REPLICATION_ZOOM_ADDRESS_GENERATOR_CORE_ASSERT_SVH
`define REPLICATION_ZOOM_ADDRESS_GENERATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RZAG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RZAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rzag_pkg.sv -----
// ----------------------------------------------------------------------------
// rzag_pkg
// Shared constants, register indexes and payload types of the zoom address
// generator.
// ----------------------------------------------------------------------------
package rzag_pkg;

  localparam int MAX_IMAGE_DIM = 4096;
  localparam int MAX_FACTOR    = 64;
  localparam int MAX_CELLS     = 256;

  // Fixed field widths.
  localparam int DEST_W    = 28;
  localparam int SRC_IDX_W = 24;
  localparam int KIND_W    = 1;

  // Widths that follow from the limits.
  localparam int DIM_W    = $clog2(MAX_IMAGE_DIM + 1);
  localparam int CENTER_W = $clog2(MAX_IMAGE_DIM);
  localparam int FACTOR_W = $clog2(MAX_FACTOR + 1);
  localparam int REP_W    = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int CELLS_W  = $clog2(MAX_CELLS + 1);
  localparam int SPAN_W   = $clog2(MAX_CELLS * MAX_FACTOR + 1);
  localparam int POS_W    = $clog2(MAX_CELLS * MAX_FACTOR);
  // Signed source coordinate: window may start left of zero, and mid-frame
  // factor changes can push the column a few windows past the image.
  localparam int SRC_W    = $clog2(MAX_IMAGE_DIM + 8 * MAX_CELLS) + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_ZOOM_FACTOR  = 3'd2,
    REG_CELLS_X      = 3'd3,
    REG_CELLS_Y      = 3'd4
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = DIM_W'(512);
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = DIM_W'(512);
  localparam logic [FACTOR_W-1:0] RST_ZOOM_FACTOR  = FACTOR_W'(4);
  localparam logic [CELLS_W-1:0]  RST_CELLS_X      = CELLS_W'(33);
  localparam logic [CELLS_W-1:0]  RST_CELLS_Y      = CELLS_W'(33);

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } item_t;

  typedef struct packed {
    logic [DEST_W-1:0]    dest_index;
    logic [SRC_IDX_W-1:0] source_index;
    logic                 zero_fill;
    logic                 pixel_valid;
    logic                 frame_last;
    logic                 rejected;
  } result_t;

  // Settings as the walker uses them: clamped and with window spans.
  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [FACTOR_W-1:0] factor;
    logic [CELLS_W-1:0]  cells_x;
    logic [CELLS_W-1:0]  cells_y;
    logic [SPAN_W-1:0]   span_x;
    logic [SPAN_W-1:0]   span_y;
  } zoom_cfg_t;

  typedef struct packed {
    logic active;
  } walk_status_t;

endpackage

// ----- design/rzag_in_if.sv -----
// ----------------------------------------------------------------------------
// rzag_in_if
// Input channel: start or advance beats with the zoom centre.
// ----------------------------------------------------------------------------
interface rzag_in_if;
  logic                          valid;
  logic                          ready;
  logic [rzag_pkg::KIND_W-1:0]   kind;
  logic [rzag_pkg::CENTER_W-1:0] center_x;
  logic [rzag_pkg::CENTER_W-1:0] center_y;

  modport source(output valid, output kind, output center_x, output center_y, input ready);
  modport sink(input valid, input kind, input center_x, input center_y, output ready);
endinterface

// ----- design/rzag_out_if.sv -----
// ----------------------------------------------------------------------------
// rzag_out_if
// Result channel: one beat per input beat.
// ----------------------------------------------------------------------------
interface rzag_out_if;
  logic                           valid;
  logic                           ready;
  logic [rzag_pkg::DEST_W-1:0]    dest_index;
  logic [rzag_pkg::SRC_IDX_W-1:0] source_index;
  logic                           zero_fill;
  logic                           pixel_valid;
  logic                           frame_last;
  logic                           rejected;

  modport source(output valid, output dest_index, output source_index, output zero_fill,
                 output pixel_valid, output frame_last, output rejected, input ready);
  modport sink(input valid, input dest_index, input source_index, input zero_fill,
               input pixel_valid, input frame_last, input rejected, output ready);
endinterface

// ----- design/rzag_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rzag_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rzag_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rzag_pkg::CFG_IDX_W-1:0]  index;
  logic [rzag_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- design/rzag_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rzag_cfg_regs
// Configuration registers, plus registered clamped values and window spans.
// ----------------------------------------------------------------------------
module rzag_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  rzag_cfg_if.sink            cfg_bus,
  output rzag_pkg::zoom_cfg_t zoom_cfg
);

  logic [rzag_pkg::DIM_W-1:0]    image_width_r;
  logic [rzag_pkg::DIM_W-1:0]    image_height_r;
  logic [rzag_pkg::FACTOR_W-1:0] zoom_factor_r;
  logic [rzag_pkg::CELLS_W-1:0]  cells_x_r;
  logic [rzag_pkg::CELLS_W-1:0]  cells_y_r;

  logic [rzag_pkg::FACTOR_W-1:0] factor_c;
  logic [rzag_pkg::CELLS_W-1:0]  cells_x_c;
  logic [rzag_pkg::CELLS_W-1:0]  cells_y_c;
  rzag_pkg::zoom_cfg_t           zoom_cfg_r;
  rzag_pkg::zoom_cfg_t           zoom_cfg_nxt;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= rzag_pkg::RST_IMAGE_WIDTH;
      image_height_r <= rzag_pkg::RST_IMAGE_HEIGHT;
      zoom_factor_r  <= rzag_pkg::RST_ZOOM_FACTOR;
      cells_x_r      <= rzag_pkg::RST_CELLS_X;
      cells_y_r      <= rzag_pkg::RST_CELLS_Y;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        rzag_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_bus.data[rzag_pkg::DIM_W-1:0];
        rzag_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_bus.data[rzag_pkg::DIM_W-1:0];
        rzag_pkg::REG_ZOOM_FACTOR:  zoom_factor_r  <= cfg_bus.data[rzag_pkg::FACTOR_W-1:0];
        rzag_pkg::REG_CELLS_X:      cells_x_r      <= cfg_bus.data[rzag_pkg::CELLS_W-1:0];
        rzag_pkg::REG_CELLS_Y:      cells_y_r      <= cfg_bus.data[rzag_pkg::CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the limit saturates.
  always_comb begin
    if (zoom_factor_r == '0) begin
      factor_c = rzag_pkg::FACTOR_W'(1);
    end else if (zoom_factor_r > rzag_pkg::FACTOR_W'(rzag_pkg::MAX_FACTOR)) begin
      factor_c = rzag_pkg::FACTOR_W'(rzag_pkg::MAX_FACTOR);
    end else begin
      factor_c = zoom_factor_r;
    end
    if (cells_x_r == '0) begin
      cells_x_c = rzag_pkg::CELLS_W'(1);
    end else if (cells_x_r > rzag_pkg::CELLS_W'(rzag_pkg::MAX_CELLS)) begin
      cells_x_c = rzag_pkg::CELLS_W'(rzag_pkg::MAX_CELLS);
    end else begin
      cells_x_c = cells_x_r;
    end
    if (cells_y_r == '0) begin
      cells_y_c = rzag_pkg::CELLS_W'(1);
    end else if (cells_y_r > rzag_pkg::CELLS_W'(rzag_pkg::MAX_CELLS)) begin
      cells_y_c = rzag_pkg::CELLS_W'(rzag_pkg::MAX_CELLS);
    end else begin
      cells_y_c = cells_y_r;
    end
  end

  always_comb begin
    zoom_cfg_nxt.image_width  = image_width_r;
    zoom_cfg_nxt.image_height = image_height_r;
    zoom_cfg_nxt.factor       = factor_c;
    zoom_cfg_nxt.cells_x      = cells_x_c;
    zoom_cfg_nxt.cells_y      = cells_y_c;
    zoom_cfg_nxt.span_x       = rzag_pkg::SPAN_W'(cells_x_c) * rzag_pkg::SPAN_W'(factor_c);
    zoom_cfg_nxt.span_y       = rzag_pkg::SPAN_W'(cells_y_c) * rzag_pkg::SPAN_W'(factor_c);
  end

  // Registered copy of the clamped settings and spans that the walker reads.
  always_ff @(posedge clk) begin
    zoom_cfg_r <= zoom_cfg_nxt;
  end

  assign zoom_cfg = zoom_cfg_r;

endmodule

// ----- design/rzag_walker.sv -----
// ----------------------------------------------------------------------------
// rzag_walker
// Frame state and raster walk: builds the result of one beat and steps the
// output, replication and source counters.
// ----------------------------------------------------------------------------
module rzag_walker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  rzag_pkg::item_t        item,
  input  rzag_pkg::zoom_cfg_t    zoom_cfg,
  output rzag_pkg::result_t      result,
  output rzag_pkg::walk_status_t status
);

  logic                                active_r,     active_nxt;
  logic signed [rzag_pkg::SRC_W-1:0]   origin_x_r,   origin_x_nxt;
  logic signed [rzag_pkg::SRC_W-1:0]   origin_y_r,   origin_y_nxt;
  logic        [rzag_pkg::POS_W-1:0]   out_col_r,    out_col_nxt;
  logic        [rzag_pkg::POS_W-1:0]   out_row_r,    out_row_nxt;
  logic        [rzag_pkg::REP_W-1:0]   rep_col_r,    rep_col_nxt;
  logic        [rzag_pkg::REP_W-1:0]   rep_row_r,    rep_row_nxt;
  logic signed [rzag_pkg::SRC_W-1:0]   src_col_r,    src_col_nxt;
  logic signed [rzag_pkg::SRC_W-1:0]   src_row_r,    src_row_nxt;
  logic        [rzag_pkg::DEST_W-1:0]  dest_count_r, dest_count_nxt;

  logic                                start_bad;
  logic                                outside;
  logic                                row_end;
  logic                                frame_end;
  logic                                col_rep_done;
  logic                                row_rep_done;
  logic signed [rzag_pkg::SRC_W-1:0]   start_x;
  logic signed [rzag_pkg::SRC_W-1:0]   start_y;
  logic        [2*rzag_pkg::DIM_W-1:0] row_base;
  logic        [2*rzag_pkg::DIM_W-1:0] src_sum;

  assign start_bad = (rzag_pkg::DIM_W'(item.center_x) >= zoom_cfg.image_width) ||
                     (rzag_pkg::DIM_W'(item.center_y) >= zoom_cfg.image_height);

  assign start_x = $signed(rzag_pkg::SRC_W'(item.center_x)) -
                   $signed(rzag_pkg::SRC_W'(zoom_cfg.cells_x >> 1));
  assign start_y = $signed(rzag_pkg::SRC_W'(item.center_y)) -
                   $signed(rzag_pkg::SRC_W'(zoom_cfg.cells_y >> 1));

  // A negative coordinate reads as a huge unsigned value, so one compare per
  // axis covers both edges of the image.
  assign outside = ($unsigned(src_col_r) >= rzag_pkg::SRC_W'(zoom_cfg.image_width)) ||
                   ($unsigned(src_row_r) >= rzag_pkg::SRC_W'(zoom_cfg.image_height));

  assign row_base = src_row_r[rzag_pkg::DIM_W-1:0] * zoom_cfg.image_width;
  assign src_sum  = row_base + (2*rzag_pkg::DIM_W)'(src_col_r[rzag_pkg::DIM_W-1:0]);

  assign row_end   = (rzag_pkg::SPAN_W'(out_col_r) + 1'b1) >= zoom_cfg.span_x;
  assign frame_end = row_end && ((rzag_pkg::SPAN_W'(out_row_r) + 1'b1) >= zoom_cfg.span_y);

  assign col_rep_done = (rzag_pkg::FACTOR_W'(rep_col_r) + 1'b1) >= zoom_cfg.factor;
  assign row_rep_done = (rzag_pkg::FACTOR_W'(rep_row_r) + 1'b1) >= zoom_cfg.factor;

  always_comb begin
    result         = '0;
    active_nxt     = active_r;
    origin_x_nxt   = origin_x_r;
    origin_y_nxt   = origin_y_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    rep_col_nxt    = rep_col_r;
    rep_row_nxt    = rep_row_r;
    src_col_nxt    = src_col_r;
    src_row_nxt    = src_row_r;
    dest_count_nxt = dest_count_r;

    if (item.kind == rzag_pkg::KIND_START) begin
      if (start_bad) begin
        result.rejected = 1'b1;
      end else begin
        // Restart the frame even if one is running.
        origin_x_nxt   = start_x;
        origin_y_nxt   = start_y;
        src_col_nxt    = start_x;
        src_row_nxt    = start_y;
        out_col_nxt    = '0;
        out_row_nxt    = '0;
        rep_col_nxt    = '0;
        rep_row_nxt    = '0;
        dest_count_nxt = '0;
        active_nxt     = 1'b1;
      end
    end else if (!active_r) begin
      result.rejected = 1'b1;
    end else begin
      result.dest_index   = dest_count_r;
      result.source_index = outside ? '0 : rzag_pkg::SRC_IDX_W'(src_sum);
      result.zero_fill    = outside;
      result.pixel_valid  = 1'b1;
      result.frame_last   = frame_end;
      dest_count_nxt      = dest_count_r + 1'b1;
      if (frame_end) begin
        active_nxt = 1'b0;
      end else if (row_end) begin
        out_col_nxt = '0;
        rep_col_nxt = '0;
        src_col_nxt = origin_x_r;
        out_row_nxt = out_row_r + 1'b1;
        if (row_rep_done) begin
          rep_row_nxt = '0;
          src_row_nxt = src_row_r + rzag_pkg::SRC_W'(1);
        end else begin
          rep_row_nxt = rep_row_r + 1'b1;
        end
      end else begin
        out_col_nxt = out_col_r + 1'b1;
        if (col_rep_done) begin
          rep_col_nxt = '0;
          src_col_nxt = src_col_r + rzag_pkg::SRC_W'(1);
        end else begin
          rep_col_nxt = rep_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      rep_col_r    <= '0;
      rep_row_r    <= '0;
      src_col_r    <= '0;
      src_row_r    <= '0;
      dest_count_r <= '0;
    end else if (step) begin
      active_r     <= active_nxt;
      origin_x_r   <= origin_x_nxt;
      origin_y_r   <= origin_y_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      rep_col_r    <= rep_col_nxt;
      rep_row_r    <= rep_row_nxt;
      src_col_r    <= src_col_nxt;
      src_row_r    <= src_row_nxt;
      dest_count_r <= dest_count_nxt;
    end
  end

  assign status.active = active_r;

endmodule

// ----- design/replication_zoom_address_generator_core.sv -----
// ----------------------------------------------------------------------------
// replication_zoom_address_generator_core
// Pixel-replication zoom address generator: one result beat per input beat.
// ----------------------------------------------------------------------------
// A start beat (kind 0) opens a zoomed frame around a centre point, or is
// rejected when the centre is outside the image. An advance beat (kind 1)
// is rejected while no frame is open, else yields the next raster-order pixel
// with destination and source index, zero-fill flag, frame_last on the last.
// The block takes one beat per clock while the output is not stalled: a beat
// waits in the input register while the walker forms its result and steps the
// frame counters, and the result then waits in the output register until it
// is taken. The path that sets the clock is the source row times image width
// product plus column in the walker. Configuration writes pass through the
// setting registers and the registered clamped copy; the user must make them
// while no beat is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module replication_zoom_address_generator_core (
  input  logic       clk,
  input  logic       rst_n,
  rzag_in_if.sink    in_bus,
  rzag_out_if.source out_bus,
  rzag_cfg_if.sink   cfg_bus
);

  rzag_pkg::item_t        s1_item_r;
  logic                   s1_valid_r;
  rzag_pkg::result_t      res_r;
  logic                   out_valid_r;
  rzag_pkg::result_t      walk_result;
  rzag_pkg::walk_status_t walk_status;
  rzag_pkg::zoom_cfg_t    zoom_cfg;
  logic                   out_free;
  logic                   step;
  logic                   in_fire;

  assign out_free     = !out_valid_r || out_bus.ready;
  assign step         = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign in_fire      = in_bus.valid && in_bus.ready;

  rzag_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_bus  (cfg_bus),
    .zoom_cfg (zoom_cfg)
  );

  rzag_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (s1_item_r),
    .zoom_cfg (zoom_cfg),
    .result   (walk_result),
    .status   (walk_status)
  );

  // Input stage: hold the beat until the walker consumes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.kind     <= in_bus.kind;
      s1_item_r.center_x <= in_bus.center_x;
      s1_item_r.center_y <= in_bus.center_y;
    end
  end

  // Output stage: advance when empty or drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= walk_result;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.dest_index   = res_r.dest_index;
  assign out_bus.source_index = res_r.source_index;
  assign out_bus.zero_fill    = res_r.zero_fill;
  assign out_bus.pixel_valid  = res_r.pixel_valid;
  assign out_bus.frame_last   = res_r.frame_last;
  assign out_bus.rejected     = res_r.rejected;

`include "replication_zoom_address_generator_core_assert.svh"

  `RZAG_ASSERT_NEXT(a_last_ends_frame, step && walk_result.frame_last, !walk_status.active, "frame still active after last pixel")
  `RZAG_ASSERT_SAME(a_fill_has_zero_src, out_valid_r && res_r.zero_fill, res_r.pixel_valid && (res_r.source_index == '0), "zero-filled pixel with nonzero source")
  `RZAG_ASSERT_SAME(a_reject_no_pixel, out_valid_r && res_r.rejected, !res_r.pixel_valid && !res_r.frame_last, "rejected beat carries a pixel")
  `RZAG_ASSERT_SAME(a_stall_blocks_in, s1_valid_r && out_valid_r && !out_bus.ready, !in_bus.ready, "input taken while both stages are full")

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel-replication zoom address generator. A
// predictor in this file walks each zoomed frame one beat at a time. Every
// result beat is compared field by field with the oldest prediction. The
// directed tests cover rejects, tiny windows, zero image sizes, saturated
// settings and register writes in the middle of a frame. A back-to-back
// stream follows, then random frames run under many settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int TOTAL_BEATS  = 900;
  localparam int IDLE_PCT     = 8;

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  rzag_in_if  in_bus();
  rzag_out_if out_bus();
  rzag_cfg_if cfg_bus();

  replication_zoom_address_generator_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  // Settings as last written, unclamped.
  logic [rzag_pkg::DIM_W-1:0]    img_w   = rzag_pkg::RST_IMAGE_WIDTH;
  logic [rzag_pkg::DIM_W-1:0]    img_h   = rzag_pkg::RST_IMAGE_HEIGHT;
  logic [rzag_pkg::FACTOR_W-1:0] zoom_f  = rzag_pkg::RST_ZOOM_FACTOR;
  logic [rzag_pkg::CELLS_W-1:0]  cells_w = rzag_pkg::RST_CELLS_X;
  logic [rzag_pkg::CELLS_W-1:0]  cells_h = rzag_pkg::RST_CELLS_Y;

  // Frame walk state.
  bit                          walking;
  int                          org_col, org_row, src_c, src_r;
  int unsigned                 pix_col, pix_row, rep_c, rep_r;
  logic [rzag_pkg::DEST_W-1:0] dest_cnt = '0;

  rzag_pkg::result_t pixel_results_due[$];
  rzag_pkg::result_t oldest_due;
  bit                calm;
  int                beats_sent, settings_loaded, mismatches;
  int                pixels_seen, frame_ends, zero_fills, rejects;
  int unsigned       cycles;

  function automatic int unsigned clamp_setting(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic rzag_pkg::result_t predict_zoom_pixel(
      rzag_pkg::kind_t k, logic [rzag_pkg::CENTER_W-1:0] cx,
      logic [rzag_pkg::CENTER_W-1:0] cy);
    rzag_pkg::result_t r;
    int unsigned       f, ncx, ncy, zw, zh;
    bit                outside, row_end, last;
    logic [63:0]       flat;
    r = '0;
    f = clamp_setting(zoom_f, rzag_pkg::MAX_FACTOR);
    ncx = clamp_setting(cells_w, rzag_pkg::MAX_CELLS);
    ncy = clamp_setting(cells_h, rzag_pkg::MAX_CELLS);
    zw = ncx * f;
    zh = ncy * f;
    if (k == rzag_pkg::KIND_START) begin
      if (cx >= img_w || cy >= img_h) begin
        r.rejected = 1'b1;
        return r;
      end
      org_col = int'(cx) - int'(ncx / 2);
      org_row = int'(cy) - int'(ncy / 2);
      src_c = org_col;
      src_r = org_row;
      pix_col = 0;
      pix_row = 0;
      rep_c = 0;
      rep_r = 0;
      dest_cnt = '0;
      walking = 1'b1;
      return r;
    end
    if (!walking) begin
      r.rejected = 1'b1;
      return r;
    end
    outside = src_c < 0 || src_r < 0 || src_c >= int'(img_w) || src_r >= int'(img_h);
    row_end = pix_col + 1 >= zw;
    last = row_end && (pix_row + 1 >= zh);
    flat = 64'(src_r) * 64'(img_w) + 64'(src_c);
    r.dest_index = dest_cnt;
    r.source_index = outside ? '0 : flat[rzag_pkg::SRC_IDX_W-1:0];
    r.zero_fill = outside;
    r.pixel_valid = 1'b1;
    r.frame_last = last;
    dest_cnt = dest_cnt + 1'b1;
    if (last) begin
      walking = 1'b0;
    end else if (row_end) begin
      pix_col = 0;
      rep_c = 0;
      src_c = org_col;
      pix_row++;
      if (rep_r + 1 >= f) begin
        rep_r = 0;
        src_r++;
      end else begin
        rep_r++;
      end
    end else begin
      pix_col++;
      if (rep_c + 1 >= f) begin
        rep_c = 0;
        src_c++;
      end else begin
        rep_c++;
      end
    end
    return r;
  endfunction

  function automatic int pick_center(int dim);
    if (dim > 0 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, ((dim > rzag_pkg::MAX_IMAGE_DIM) ?
                                rzag_pkg::MAX_IMAGE_DIM : dim) - 1);
    return $urandom_range(0, rzag_pkg::MAX_IMAGE_DIM - 1);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Hold valid high across back-to-back register beats; the caller drops it.
  task automatic write_reg(input rzag_pkg::cfg_reg_t idx, input int v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= rzag_pkg::CFG_DATA_W'(v);
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      rzag_pkg::REG_IMAGE_WIDTH:  img_w   = rzag_pkg::DIM_W'(v);
      rzag_pkg::REG_IMAGE_HEIGHT: img_h   = rzag_pkg::DIM_W'(v);
      rzag_pkg::REG_ZOOM_FACTOR:  zoom_f  = rzag_pkg::FACTOR_W'(v);
      rzag_pkg::REG_CELLS_X:      cells_w = rzag_pkg::CELLS_W'(v);
      rzag_pkg::REG_CELLS_Y:      cells_h = rzag_pkg::CELLS_W'(v);
      default: ;
    endcase
  endtask

  task automatic load_zoom_settings(input int w, input int h, input int f,
                                    input int nx, input int ny);
    write_reg(rzag_pkg::REG_IMAGE_WIDTH, w);
    write_reg(rzag_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(rzag_pkg::REG_ZOOM_FACTOR, f);
    write_reg(rzag_pkg::REG_CELLS_X, nx);
    write_reg(rzag_pkg::REG_CELLS_Y, ny);
    cfg_bus.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_beat(input rzag_pkg::kind_t k, input int cx, input int cy,
                           output rzag_pkg::result_t predicted);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.kind     <= k;
    in_bus.center_x <= rzag_pkg::CENTER_W'(cx);
    in_bus.center_y <= rzag_pkg::CENTER_W'(cy);
    do @(posedge clk); while (!in_bus.ready);
    predicted = predict_zoom_pixel(k, rzag_pkg::CENTER_W'(cx), rzag_pkg::CENTER_W'(cy));
    pixel_results_due.push_back(predicted);
    beats_sent++;
  endtask

  task automatic finish_pending();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pixel_results_due.size() != 0);
  endtask

  task automatic advance_to_end(input int max_adv);
    rzag_pkg::result_t p;
    int                n;
    n = 0;
    while (walking && n < max_adv) begin
      send_beat(rzag_pkg::KIND_ADVANCE, $urandom_range(0, 4095), $urandom_range(0, 4095), p);
      n++;
    end
  endtask

  task automatic run_frame(input int cx, input int cy, input int max_adv);
    rzag_pkg::result_t p;
    send_beat(rzag_pkg::KIND_START, cx, cy, p);
    if (!p.rejected) advance_to_end(max_adv);
  endtask

  task automatic test_idle_and_defaults();
    rzag_pkg::result_t p;
    send_beat(rzag_pkg::KIND_ADVANCE, 4095, 0, p);
    send_beat(rzag_pkg::KIND_START, 4095, 4095, p);
    send_beat(rzag_pkg::KIND_START, 512, 0, p);
    send_beat(rzag_pkg::KIND_START, 0, 512, p);
    run_frame(511, 511, 2);
  endtask

  // Factor zero acts as one, cells_y zero as one: a 2 by 1 window.
  task automatic test_tiny_windows();
    rzag_pkg::result_t p;
    finish_pending();
    load_zoom_settings(3, 2, 0, 2, 0);
    run_frame(0, 0, 8);
    send_beat(rzag_pkg::KIND_ADVANCE, 0, 4095, p);
    run_frame(2, 1, 8);
  endtask

  task automatic test_zero_image();
    rzag_pkg::result_t p;
    finish_pending();
    load_zoom_settings(0, 5, 1, 1, 1);
    send_beat(rzag_pkg::KIND_START, 0, 0, p);
    finish_pending();
    load_zoom_settings(5, 0, 1, 1, 1);
    send_beat(rzag_pkg::KIND_START, 0, 0, p);
  endtask

  task automatic test_saturation();
    finish_pending();
    load_zoom_settings(8191, 4096, 127, 511, 511);
    run_frame(4095, 4095, 3);
  endtask

  // Shrink the window while the column counter is past the new row end.
  task automatic test_mid_frame_write();
    finish_pending();
    load_zoom_settings(4, 4, 2, 2, 2);
    run_frame(1, 1, 3);
    finish_pending();
    load_zoom_settings(4, 4, 1, 1, 2);
    advance_to_end(8);
  endtask

  task automatic test_streaming();
    finish_pending();
    calm <= 1'b1;
    load_zoom_settings(4096, 4096, 2, 8, 8);
    run_frame($urandom_range(0, 3), $urandom_range(4092, 4095), 1000);
    finish_pending();
    calm <= 1'b0;
  endtask

  task automatic test_random_frames();
    int                w, h, f, nx, ny, r;
    rzag_pkg::result_t p;
    while (beats_sent < TOTAL_BEATS) begin
      finish_pending();
      if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(4096, 8191);
        h = $urandom_range(4096, 8191);
      end else begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 40);
      end
      f = $urandom_range(0, 4);
      nx = $urandom_range(0, 5);
      ny = $urandom_range(0, 5);
      // Set bits above each register's width; they must be dropped.
      if ($urandom_range(0, 3) == 0) begin
        f += $urandom_range(1, 63) << rzag_pkg::FACTOR_W;
        nx += $urandom_range(1, 15) << rzag_pkg::CELLS_W;
        ny += $urandom_range(1, 15) << rzag_pkg::CELLS_W;
      end
      load_zoom_settings(w, h, f, nx, ny);
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_beat(rzag_pkg::kind_t'($urandom_range(0, 1)), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), p);
        end else if (r < 20) begin
          run_frame(pick_center(w), pick_center(h), $urandom_range(0, 12));
        end else begin
          run_frame(pick_center(w), pick_center(h), 1 << 20);
          if ($urandom_range(0, 4) == 0)
            send_beat(rzag_pkg::KIND_ADVANCE, $urandom_range(0, 4095),
                      $urandom_range(0, 4095), p);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pixel_results_due.size() == 0) begin
        $display("%0t result beat with nothing due: dest %0h src %0h flags %b%b%b%b",
                 $time, out_bus.dest_index, out_bus.source_index, out_bus.zero_fill,
                 out_bus.pixel_valid, out_bus.frame_last, out_bus.rejected);
        mismatches++;
      end else begin
        oldest_due = pixel_results_due.pop_front();
        check_field("dest_index", oldest_due.dest_index, out_bus.dest_index);
        check_field("source_index", oldest_due.source_index, out_bus.source_index);
        check_field("zero_fill", oldest_due.zero_fill, out_bus.zero_fill);
        check_field("pixel_valid", oldest_due.pixel_valid, out_bus.pixel_valid);
        check_field("frame_last", oldest_due.frame_last, out_bus.frame_last);
        check_field("rejected", oldest_due.rejected, out_bus.rejected);
      end
      pixels_seen += out_bus.pixel_valid;
      frame_ends  += out_bus.frame_last;
      zero_fills  += out_bus.zero_fill;
      rejects     += out_bus.rejected;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.kind     <= rzag_pkg::KIND_START;
    in_bus.center_x <= '0;
    in_bus.center_y <= '0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= rzag_pkg::REG_IMAGE_WIDTH;
    cfg_bus.data    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_defaults();
    test_tiny_windows();
    test_zero_image();
    test_saturation();
    test_mid_frame_write();
    test_streaming();
    test_random_frames();
    finish_pending();
    repeat (8) @(posedge clk);
    $display("Checked %0d beats under %0d register settings: %0d pixels, %0d frame ends,",
             beats_sent, settings_loaded, pixels_seen, frame_ends);
    $display("%0d zero-filled pixels and %0d rejected beats.", zero_fills, rejects);
    if (mismatches == 0 && pixel_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- replication_zoom_address_generator_core.f -----
+incdir+design
design/rzag_pkg.sv
design/rzag_in_if.sv
design/rzag_out_if.sv
design/rzag_cfg_if.sv
design/rzag_cfg_regs.sv
design/rzag_walker.sv
design/replication_zoom_address_generator_core.sv
sim/tb.sv
